// ===== rtl/rmq_pkg.sv =====
// Shared types, widths and helpers for the rotation matrix to quaternion converter.
`timescale 1ns / 1ps
package rmq_pkg;
	localparam int FRAC_BITS = 14;
	localparam int ELEM_W = 16;
	localparam int E_W = ELEM_W + 3;
	localparam int SUM_W = ELEM_W + 1;
	localparam int MAG_W = SUM_W;
	localparam int SQ_W = ((E_W - 1 + FRAC_BITS + 1) / 2) * 2;
	localparam int ROOT_W = SQ_W / 2;
	localparam int REM_W = ROOT_W + 3;
	localparam int NUM_W = MAG_W + FRAC_BITS + 1;
	localparam int Q_W = NUM_W - (FRAC_BITS + 1);
	localparam int DRW = ROOT_W + 2;
	localparam int ONE = 1 << FRAC_BITS;
	localparam int QMAX = (1 << (ELEM_W - 1)) - 1;
	localparam int ONE_SAT = (ONE > QMAX) ? QMAX : ONE;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [SUM_W-1:0] pair_t;

	typedef enum logic [1:0] {SEL_X, SEL_Y, SEL_Z, SEL_W} sel_t;

	typedef struct packed {
		sel_t best;
		logic bad;
		pair_t d0;
		pair_t d1;
		pair_t d2;
	} item_t;

	typedef struct packed {
		item_t item;
		logic [SQ_W-1:0] n;
	} req_t;

	function automatic elem_t sat_root(input logic [ROOT_W:0] v);
		if (v > (ROOT_W+1)'(QMAX))
			return elem_t'(QMAX);
		return elem_t'(v);
	endfunction

	function automatic elem_t sat_quot(input logic [Q_W-1:0] q, input logic neg);
		logic [Q_W-1:0] nq;
		nq = -q;
		if (neg) begin
			if (q > Q_W'(QMAX + 1))
				return elem_t'(-QMAX - 1);
			return nq[ELEM_W-1:0];
		end
		if (q > Q_W'(QMAX))
			return elem_t'(QMAX);
		return q[ELEM_W-1:0];
	endfunction
endpackage

// ===== rtl/rmq_front.sv =====
// Front end: candidate terms, dominant axis selection and off-diagonal pair sums.
`timescale 1ns / 1ps
module rmq_front import rmq_pkg::*; (
	input  elem_t m11,
	input  elem_t m12,
	input  elem_t m13,
	input  elem_t m21,
	input  elem_t m22,
	input  elem_t m23,
	input  elem_t m31,
	input  elem_t m32,
	input  elem_t m33,
	output req_t  req
);
	logic signed [E_W-1:0] x11, x22, x33, e0, e1, e2, e3, eb;
	pair_t sxy, sxz, syz, dw0, dw1, dw2;
	sel_t best;
	logic bad;

	assign x11 = E_W'(m11);
	assign x22 = E_W'(m22);
	assign x33 = E_W'(m33);
	assign e0 = x11 - x22 - x33 + E_W'(ONE);
	assign e1 = -x11 + x22 - x33 + E_W'(ONE);
	assign e2 = -x11 - x22 + x33 + E_W'(ONE);
	assign e3 = x11 + x22 + x33 + E_W'(ONE);

	assign sxy = SUM_W'(m12) + SUM_W'(m21);
	assign sxz = SUM_W'(m31) + SUM_W'(m13);
	assign syz = SUM_W'(m23) + SUM_W'(m32);
	assign dw0 = SUM_W'(m32) - SUM_W'(m23);
	assign dw1 = SUM_W'(m13) - SUM_W'(m31);
	assign dw2 = SUM_W'(m21) - SUM_W'(m12);

	always_comb begin
		best = SEL_X;
		eb = e0;
		if (e1 > eb) begin
			best = SEL_Y;
			eb = e1;
		end
		if (e2 > eb) begin
			best = SEL_Z;
			eb = e2;
		end
		if (e3 > eb) begin
			best = SEL_W;
			eb = e3;
		end
		bad = eb[E_W-1];
		req.item.best = best;
		req.item.bad = bad;
		req.n = bad ? '0 : SQ_W'({eb[E_W-2:0], {FRAC_BITS{1'b0}}});
		unique case (best)
			SEL_X: begin
				req.item.d0 = sxy;
				req.item.d1 = sxz;
				req.item.d2 = dw0;
			end
			SEL_Y: begin
				req.item.d0 = sxy;
				req.item.d1 = syz;
				req.item.d2 = dw1;
			end
			SEL_Z: begin
				req.item.d0 = sxz;
				req.item.d1 = syz;
				req.item.d2 = dw2;
			end
			default: begin
				req.item.d0 = dw0;
				req.item.d1 = dw1;
				req.item.d2 = dw2;
			end
		endcase
	end
endmodule

// ===== rtl/rmq_queue.sv =====
// Short request queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
module rmq_queue import rmq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  req_t wdata,
	output logic full,
	input  logic rd,
	output req_t rdata,
	output logic empty
);
	req_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0] cnt_q;
	logic do_wr, do_rd;

	assign full = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= wp_q + 1'b1;
			if (do_rd)
				rp_q <= rp_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// ===== rtl/rmq_back.sv =====
// Back end: pipelined square root, three pipelined dividers and the result register.
`timescale 1ns / 1ps
module rmq_back import rmq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  req_t  in_req,
	output logic  in_take,
	output logic  out_valid,
	input  logic  out_pop,
	output elem_t quat_x,
	output elem_t quat_y,
	output elem_t quat_z,
	output elem_t quat_w,
	output logic  bad_matrix
);
	typedef struct packed {
		item_t item;
		logic [SQ_W-1:0] n;
		logic [REM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		item_t item;
		logic [ROOT_W-1:0] root;
		logic [2:0][DRW-1:0] rem;
		logic [2:0][Q_W-1:0] quo;
		logic [2:0][Q_W-1:0] num;
		logic [2:0] neg;
	} dv_t;

	logic en;
	logic out_valid_q;

	sq_t sqrt_sk [ROOT_W];
	sq_t sq_w [ROOT_W+1];
	logic [ROOT_W:0] sqv_w;
	logic [ROOT_W-1:0] sqrt_v_q;

	dv_t div_sk [Q_W];
	dv_t dv_w [Q_W+1];
	logic [Q_W:0] dvv_w;
	logic [Q_W-1:0] div_v_q;

	assign en = !out_valid_q || out_pop;
	assign in_take = en && in_valid;
	assign out_valid = out_valid_q;

	assign sq_w[0] = '{item: in_req.item, n: in_req.n, rem: '0, root: '0};
	assign sqv_w[0] = in_valid;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		sq_t nxt;
		logic [REM_W-1:0] rem_sh, trial;

		always_comb begin
			nxt = sq_w[k];
			rem_sh = {sq_w[k].rem[REM_W-3:0], sq_w[k].n[SQ_W-1-2*k -: 2]};
			trial = {1'b0, sq_w[k].root, 2'b01};
			if (rem_sh >= trial) begin
				nxt.rem = rem_sh - trial;
				nxt.root = {sq_w[k].root[ROOT_W-2:0], 1'b1};
			end else begin
				nxt.rem = rem_sh;
				nxt.root = {sq_w[k].root[ROOT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en)
				sqrt_sk[k] <= nxt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sqrt_v_q[k] <= 1'b0;
			else if (en)
				sqrt_v_q[k] <= sqv_w[k];
		end

		assign sq_w[k+1] = sqrt_sk[k];
		assign sqv_w[k+1] = sqrt_v_q[k];
	end

	always_comb begin
		pair_t s;
		logic [MAG_W-1:0] mag;
		logic [NUM_W-1:0] num;
		dv_w[0].item = sq_w[ROOT_W].item;
		dv_w[0].root = sq_w[ROOT_W].root;
		for (int i = 0; i < 3; i++) begin
			if (i == 0)
				s = sq_w[ROOT_W].item.d0;
			else if (i == 1)
				s = sq_w[ROOT_W].item.d1;
			else
				s = sq_w[ROOT_W].item.d2;
			mag = s[SUM_W-1] ? MAG_W'(-s) : MAG_W'(s);
			num = NUM_W'({mag, {FRAC_BITS{1'b0}}}) + NUM_W'(sq_w[ROOT_W].root);
			dv_w[0].neg[i] = s[SUM_W-1];
			dv_w[0].rem[i] = DRW'(num[NUM_W-1:Q_W]);
			dv_w[0].num[i] = num[Q_W-1:0];
			dv_w[0].quo[i] = '0;
		end
	end
	assign dvv_w[0] = sqv_w[ROOT_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_div
		dv_t nxt;
		logic [DRW-1:0] rem_sh, den;

		always_comb begin
			nxt = dv_w[j];
			den = {1'b0, dv_w[j].root, 1'b0};
			rem_sh = '0;
			for (int i = 0; i < 3; i++) begin
				rem_sh = {dv_w[j].rem[i][DRW-2:0], dv_w[j].num[i][Q_W-1-j]};
				if (rem_sh >= den) begin
					nxt.rem[i] = rem_sh - den;
					nxt.quo[i] = {dv_w[j].quo[i][Q_W-2:0], 1'b1};
				end else begin
					nxt.rem[i] = rem_sh;
					nxt.quo[i] = {dv_w[j].quo[i][Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en)
				div_sk[j] <= nxt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				div_v_q[j] <= 1'b0;
			else if (en)
				div_v_q[j] <= dvv_w[j];
		end

		assign dv_w[j+1] = div_sk[j];
		assign dvv_w[j+1] = div_v_q[j];
	end

	dv_t fin;
	elem_t v, c0, c1, c2;
	elem_t qx, qy, qz, qw;

	assign fin = dv_w[Q_W];
	assign v = sat_root((ROOT_W+1)'(fin.root) + 1'b1 >> 1);
	assign c0 = sat_quot(fin.quo[0], fin.neg[0]);
	assign c1 = sat_quot(fin.quo[1], fin.neg[1]);
	assign c2 = sat_quot(fin.quo[2], fin.neg[2]);

	always_comb begin
		if (fin.item.bad) begin
			qx = '0;
			qy = '0;
			qz = '0;
			qw = elem_t'(ONE_SAT);
		end else begin
			unique case (fin.item.best)
				SEL_X: begin
					qx = v;
					qy = c0;
					qz = c1;
					qw = c2;
				end
				SEL_Y: begin
					qx = c0;
					qy = v;
					qz = c1;
					qw = c2;
				end
				SEL_Z: begin
					qx = c0;
					qy = c1;
					qz = v;
					qw = c2;
				end
				default: begin
					qx = c0;
					qy = c1;
					qz = c2;
					qw = v;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat_x <= qx;
			quat_y <= qy;
			quat_z <= qz;
			quat_w <= qw;
			bad_matrix <= fin.item.bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= dvv_w[Q_W];
	end
endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Top level of the rotation matrix to quaternion converter (Shepperd's method).
//
//   channel   handshake            payload
//   request   push / full          m11 m12 m13 m21 m22 m23 m31 m32 m33
//   result    empty / pop          quat_x quat_y quat_z quat_w bad_matrix
//
// One request per cycle is accepted while the queue is not full; a request passes through
// 16 square root stages, 17 divider stages and one result register on its way to the result ports.
// Reset clears the queue and all stage valid flags; no clearing pass is needed.
// A held result stalls the whole back end; the four-entry queue keeps taking requests meanwhile until full.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion import rmq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  elem_t m11,
	input  elem_t m12,
	input  elem_t m13,
	input  elem_t m21,
	input  elem_t m22,
	input  elem_t m23,
	input  elem_t m31,
	input  elem_t m32,
	input  elem_t m33,
	output logic  empty,
	input  logic  pop,
	output elem_t quat_x,
	output elem_t quat_y,
	output elem_t quat_z,
	output elem_t quat_w,
	output logic  bad_matrix
);
	req_t front_req, queue_req;
	logic queue_empty, back_take, back_valid;

	rmq_front u_front (
		.m11(m11), .m12(m12), .m13(m13),
		.m21(m21), .m22(m22), .m23(m23),
		.m31(m31), .m32(m32), .m33(m33),
		.req(front_req)
	);

	rmq_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(push),
		.wdata(front_req),
		.full(full),
		.rd(back_take),
		.rdata(queue_req),
		.empty(queue_empty)
	);

	rmq_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(!queue_empty),
		.in_req(queue_req),
		.in_take(back_take),
		.out_valid(back_valid),
		.out_pop(pop),
		.quat_x(quat_x),
		.quat_y(quat_y),
		.quat_z(quat_z),
		.quat_w(quat_w),
		.bad_matrix(bad_matrix)
	);

	assign empty = !back_valid;
endmodule
